// File: sv/sector_range_extent_mapper_top_defines.svh
// Assertion macros for the sector range extent mapper.
`ifndef SECTOR_RANGE_EXTENT_MAPPER_TOP_DEFINES_SVH
`define SECTOR_RANGE_EXTENT_MAPPER_TOP_DEFINES_SVH

// Clocked check, disabled while reset is asserted.
`define SREM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sector range extent mapper check failed");

// Clocked check that also holds during reset.
`define SREM_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("sector range extent mapper check failed during reset");

`endif

// File: sv/srem_pkg.sv
// Package with shared types and constants of the sector range extent mapper.
package srem_pkg;

  localparam int TableDepthDefault = 32;
  localparam int SlotW             = 6;
  localparam int SectorW           = 32;
  localparam int RemainW           = 21;
  localparam int SectorShift       = 11;
  localparam int OffsetW           = 43;
  localparam int EntryW            = 96;
  localparam int ApbAddrW          = 3;

  localparam logic [RemainW-1:0] MaxRequestSectors = 21'h1F_FFFF;
  localparam logic               CfgIdxEntries     = 1'b0;

  typedef enum logic [1:0] {
    STATUS_CHUNK     = 2'd0,
    STATUS_LOAD_DONE = 2'd1,
    STATUS_TOO_LARGE = 2'd2,
    STATUS_EMPTY_OK  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_CALC,
    ST_SIZE,
    ST_EMIT,
    ST_FALL
  } state_e;

endpackage

// File: sv/srem_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module srem_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/sector_range_extent_mapper_top.sv
// Top level of the sector range extent mapper: extent table, walk sequencer and APB register.
//
// A load or a request with a zero or over-limit count answers with a single
// result in the cycle after start is taken, and busy stays low. A mapping
// request raises busy and walks the table stored in a RAM with a registered
// read: each slot examined passes a read state and then a compare state, a
// chunk from a covering slot then passes the calc, size and emit states, and
// the fallback chunk the fall state. A request gives at most TableDepth+1
// results. Every result is shown for exactly one cycle on result_valid_o and
// cannot be held off; busy falls in the cycle the final result is shown.
`include "sector_range_extent_mapper_top_defines.svh"

module sector_range_extent_mapper_top #(
  parameter int TableDepth = srem_pkg::TableDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srem_pkg::ApbAddrW-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  logic                              action_i,
  input  logic [4:0]                        entry_slot_i,
  input  logic [31:0]                       entry_start_sector_i,
  input  logic [31:0]                       entry_sector_count_i,
  input  logic [31:0]                       entry_byte_size_i,
  input  logic [31:0]                       request_start_sector_i,
  input  logic [31:0]                       request_sector_count_i,
  output logic                              result_valid_o,
  output logic [1:0]                        status_o,
  output logic [srem_pkg::SlotW-1:0]        source_slot_o,
  output logic [srem_pkg::OffsetW-1:0]      source_byte_offset_o,
  output logic [31:0]                       data_bytes_o,
  output logic [31:0]                       pad_bytes_o,
  output logic [31:0]                       dest_byte_offset_o,
  output logic                              last_o
);

  localparam int AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int NresW = $clog2(TableDepth + 2);
  localparam int SlotW = srem_pkg::SlotW;
  localparam int RemW  = srem_pkg::RemainW;
  localparam int Shift = srem_pkg::SectorShift;
  localparam int OffW  = srem_pkg::OffsetW;

  srem_pkg::state_e  state_q, state_d;
  srem_pkg::status_e out_status_q, out_status_d;

  logic [SlotW-1:0]  entries_q, entries_d;
  logic [SlotW-1:0]  searched_q, searched_d;
  logic [SlotW-1:0]  idx_q, idx_d;
  logic [31:0]       sector_q, sector_d;
  logic [RemW-1:0]   remaining_q, remaining_d;
  logic [31:0]       dest_q, dest_d;
  logic [NresW-1:0]  nres_q, nres_d;

  logic [31:0]       ent_start_q, ent_start_d;
  logic [31:0]       ent_size_q, ent_size_d;
  logic [32:0]       ent_end_q, ent_end_d;
  logic [RemW-1:0]   chunk_q, chunk_d;
  logic [OffW-1:0]   src_off_q, src_off_d;
  logic [31:0]       avail_q, avail_d;
  logic              in_range_q, in_range_d;

  logic              out_valid_q, out_valid_d;
  logic [SlotW-1:0]  out_slot_q, out_slot_d;
  logic [OffW-1:0]   out_src_q, out_src_d;
  logic [31:0]       out_data_q, out_data_d;
  logic [31:0]       out_pad_q, out_pad_d;
  logic [31:0]       out_dest_q, out_dest_d;
  logic              out_last_q, out_last_d;

  logic              accept;
  logic              cfg_write;
  logic [SlotW-1:0]  load_slot;
  logic              ram_we;
  logic [srem_pkg::EntryW-1:0] ram_wdata, ram_rdata;
  logic [31:0]       r_start, r_count;
  logic [32:0]       r_end;
  logic              r_hit;
  logic [32:0]       span;
  logic [31:0]       total;
  logic [31:0]       data_sel;
  logic [RemW-1:0]   rem_next;
  logic [SlotW-1:0]  searched_in;

  assign busy   = (state_q != srem_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == srem_pkg::CfgIdxEntries);
  assign prdata    = (paddr[2] == srem_pkg::CfgIdxEntries) ? {26'd0, entries_q} : 32'd0;
  assign entries_d = cfg_write ? pwdata[SlotW-1:0] : entries_q;

  assign load_slot = {1'b0, entry_slot_i};
  assign ram_we    = accept && !action_i && (load_slot < SlotW'(TableDepth));
  assign ram_wdata = {entry_start_sector_i, entry_sector_count_i, entry_byte_size_i};

  srem_ram #(
    .Width (srem_pkg::EntryW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (load_slot[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign r_start = ram_rdata[95:64];
  assign r_count = ram_rdata[63:32];
  assign r_end   = {1'b0, r_start} + {1'b0, r_count};
  assign r_hit   = (sector_q >= r_start) && ({1'b0, sector_q} < r_end);

  assign span        = ent_end_q - {1'b0, sector_q};
  assign total       = {chunk_q, {Shift{1'b0}}};
  assign data_sel    = in_range_q ? ((total < avail_q) ? total : avail_q) : 32'd0;
  assign rem_next    = remaining_q - chunk_q;
  assign searched_in = (entries_q > SlotW'(TableDepth)) ? SlotW'(TableDepth) : entries_q;

  always_comb begin
    state_d      = state_q;
    searched_d   = searched_q;
    idx_d        = idx_q;
    sector_d     = sector_q;
    remaining_d  = remaining_q;
    dest_d       = dest_q;
    nres_d       = nres_q;
    ent_start_d  = ent_start_q;
    ent_size_d   = ent_size_q;
    ent_end_d    = ent_end_q;
    chunk_d      = chunk_q;
    src_off_d    = src_off_q;
    avail_d      = avail_q;
    in_range_d   = in_range_q;
    out_valid_d  = 1'b0;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_src_d    = out_src_q;
    out_data_d   = out_data_q;
    out_pad_d    = out_pad_q;
    out_dest_d   = out_dest_q;
    out_last_d   = out_last_q;

    case (state_q)
      srem_pkg::ST_IDLE: begin
        if (accept) begin
          out_slot_d = '0;
          out_src_d  = '0;
          out_data_d = '0;
          out_pad_d  = '0;
          out_dest_d = '0;
          out_last_d = 1'b1;
          if (!action_i) begin
            out_valid_d  = 1'b1;
            out_status_d = srem_pkg::STATUS_LOAD_DONE;
          end else if (request_sector_count_i == 32'd0) begin
            out_valid_d  = 1'b1;
            out_status_d = srem_pkg::STATUS_EMPTY_OK;
          end else if (request_sector_count_i > 32'(srem_pkg::MaxRequestSectors)) begin
            out_valid_d  = 1'b1;
            out_status_d = srem_pkg::STATUS_TOO_LARGE;
          end else begin
            searched_d  = searched_in;
            idx_d       = '0;
            sector_d    = request_start_sector_i;
            remaining_d = request_sector_count_i[RemW-1:0];
            dest_d      = '0;
            nres_d      = '0;
            state_d     = (searched_in == '0) ? srem_pkg::ST_FALL : srem_pkg::ST_READ;
          end
        end
      end
      srem_pkg::ST_READ: begin
        state_d = srem_pkg::ST_CHECK;
      end
      srem_pkg::ST_CHECK: begin
        if (r_hit) begin
          ent_start_d = r_start;
          ent_size_d  = ram_rdata[31:0];
          ent_end_d   = r_end;
          out_slot_d  = idx_q;
          state_d     = srem_pkg::ST_CALC;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = (idx_q + 1'b1 == searched_q) ? srem_pkg::ST_FALL : srem_pkg::ST_READ;
        end
      end
      srem_pkg::ST_CALC: begin
        chunk_d   = (span < {12'd0, remaining_q}) ? span[RemW-1:0] : remaining_q;
        src_off_d = {sector_q - ent_start_q, {Shift{1'b0}}};
        state_d   = srem_pkg::ST_SIZE;
      end
      srem_pkg::ST_SIZE: begin
        in_range_d = ({11'd0, ent_size_q} > src_off_q);
        avail_d    = ent_size_q - src_off_q[31:0];
        state_d    = srem_pkg::ST_EMIT;
      end
      srem_pkg::ST_EMIT: begin
        out_valid_d  = 1'b1;
        out_status_d = srem_pkg::STATUS_CHUNK;
        out_src_d    = src_off_q;
        out_data_d   = data_sel;
        out_pad_d    = total - data_sel;
        out_dest_d   = dest_q;
        out_last_d   = (rem_next == '0);
        sector_d     = sector_q + 32'(chunk_q);
        remaining_d  = rem_next;
        dest_d       = dest_q + total;
        nres_d       = nres_q + 1'b1;
        idx_d        = '0;
        if ((rem_next == '0) || (nres_q == NresW'(TableDepth))) begin
          state_d = srem_pkg::ST_IDLE;
        end else begin
          state_d = srem_pkg::ST_READ;
        end
      end
      srem_pkg::ST_FALL: begin
        out_valid_d  = 1'b1;
        out_status_d = srem_pkg::STATUS_CHUNK;
        out_slot_d   = SlotW'(TableDepth);
        out_src_d    = {sector_q, {Shift{1'b0}}};
        out_data_d   = {remaining_q, {Shift{1'b0}}};
        out_pad_d    = '0;
        out_dest_d   = dest_q;
        out_last_d   = 1'b1;
        sector_d     = sector_q + 32'(remaining_q);
        dest_d       = dest_q + {remaining_q, {Shift{1'b0}}};
        remaining_d  = '0;
        nres_d       = nres_q + 1'b1;
        state_d      = srem_pkg::ST_IDLE;
      end
      default: begin
        state_d = srem_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srem_pkg::ST_IDLE;
      entries_q   <= '0;
      searched_q  <= '0;
      idx_q       <= '0;
      sector_q    <= '0;
      remaining_q <= '0;
      dest_q      <= '0;
      nres_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      entries_q   <= entries_d;
      searched_q  <= searched_d;
      idx_q       <= idx_d;
      sector_q    <= sector_d;
      remaining_q <= remaining_d;
      dest_q      <= dest_d;
      nres_q      <= nres_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_start_q  <= ent_start_d;
    ent_size_q   <= ent_size_d;
    ent_end_q    <= ent_end_d;
    chunk_q      <= chunk_d;
    src_off_q    <= src_off_d;
    avail_q      <= avail_d;
    in_range_q   <= in_range_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_src_q    <= out_src_d;
    out_data_q   <= out_data_d;
    out_pad_q    <= out_pad_d;
    out_dest_q   <= out_dest_d;
    out_last_q   <= out_last_d;
  end

  assign result_valid_o       = out_valid_q;
  assign status_o             = out_status_q;
  assign source_slot_o        = out_slot_q;
  assign source_byte_offset_o = out_src_q;
  assign data_bytes_o         = out_data_q;
  assign pad_bytes_o          = out_pad_q;
  assign dest_byte_offset_o   = out_dest_q;
  assign last_o               = out_last_q;

  `SREM_ASSERT(a_load_answers, accept && !action_i |=> result_valid_o && last_o && (status_o == srem_pkg::STATUS_LOAD_DONE))
  `SREM_ASSERT(a_fallback_final, result_valid_o && (status_o == srem_pkg::STATUS_CHUNK) && (source_slot_o == SlotW'(TableDepth)) |-> last_o && (pad_bytes_o == 32'd0))
  `SREM_ASSERT(a_whole_sectors, result_valid_o && (status_o == srem_pkg::STATUS_CHUNK) |-> (({1'b0, data_bytes_o} + {1'b0, pad_bytes_o}) & 33'h7FF) == 33'd0)
  `SREM_ASSERT_ALWAYS(a_walk_has_work, (state_q != srem_pkg::ST_IDLE) |-> (remaining_q != '0))

endmodule
